// ===== rtl/pea_pkg.sv =====
// ----------------------------------------------------------------------------
// pea_pkg
// Shared types and constants of the partition extent allocator: request
// codes, status codes, and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pea_pkg;

  // Defaults of the top-level parameters.
  localparam int DefTableEntries = 128;
  localparam int DefLbaBits      = 48;

  // Fixed field widths.
  localparam int SizeW    = 37;
  localparam int SecShift = 11;  // 2048 sectors per megabyte
  localparam int NeedW    = SizeW + SecShift;
  localparam int GuidW    = 64;
  localparam int OutLbaW  = 48;
  localparam int OrdW     = 7;
  localparam int CfgDataW = 48;
  localparam int CfgIdxW  = 1;
  // Width of the fit comparisons, one above the widest operand.
  localparam int CmpW     = 65;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFirstLba = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLastLba  = 1'b1;

  // Result status codes.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoSpace  = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef enum logic [1:0] {
    REQ_CREATE,
    REQ_DELETE,
    REQ_LOOKUP_GUID,
    REQ_LOOKUP_IDX
  } req_e;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_INC,
    ADDR_DEC,
    ADDR_ZERO,
    ADDR_ORD,
    ADDR_CNT
  } addr_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_NEW
  } wr_op_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ERR,
    RES_ENTRY
  } res_op_e;

  // Controller to datapath.
  typedef struct packed {
    logic     load;
    addr_op_e addr_op;
    logic     s_adv;
    logic     pos_save;
    wr_op_e   wr_op;
    logic     cnt_inc;
    logic     cnt_dec;
    res_op_e  res_op;
    logic [1:0] res_code;
  } pea_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    req_e kind;
    logic type_null;
    logic guid_null;
    logic ord_ok;
    logic full;
    logic addr_lt_cnt;
    logic addr_inc_lt_cnt;
    logic addr_eq_pos;
    logic start_lt_s;
    logic start_le_s;
    logic s_le_last;
    logic fit_in;
    logic fit_end;
    logic last_top;
    logic guid_match;
    logic out_busy;
  } pea_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pea_dp.sv =====
// ----------------------------------------------------------------------------
// pea_dp
// Datapath: configuration registers, request registers, the extent table
// memory with its registered read port, the walk pointer, search point,
// used-entry count and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pea_dp
  import pea_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries,
  parameter int LBA_BITS      = DefLbaBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Request payload.
  input  logic [1:0]           req_type_i,
  input  logic [SizeW-1:0]     size_mb_i,
  input  logic [GuidW-1:0]     type_hi_i,
  input  logic [GuidW-1:0]     type_lo_i,
  input  logic [GuidW-1:0]     part_guid_hi_i,
  input  logic [GuidW-1:0]     part_guid_lo_i,
  input  logic [OrdW-1:0]      entry_index_i,
  // Control.
  input  pea_cmd_t             cmd_i,
  output pea_stat_t            stat_o,
  // Result.
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic [OutLbaW-1:0]   start_lba_o,
  output logic [OutLbaW-1:0]   sector_count_o,
  output logic [GuidW-1:0]     out_type_hi_o,
  output logic [GuidW-1:0]     out_type_lo_o,
  output logic [GuidW-1:0]     out_guid_hi_o,
  output logic [GuidW-1:0]     out_guid_lo_o
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [GuidW-1:0]    thi;
    logic [GuidW-1:0]    tlo;
    logic [GuidW-1:0]    ghi;
    logic [GuidW-1:0]    glo;
    logic [LBA_BITS-1:0] start;
    logic [LBA_BITS-1:0] last;
  } ent_t;

  ent_t mem [TABLE_ENTRIES];
  ent_t rd_q;
  ent_t new_ent;

  logic [LBA_BITS-1:0] first_q, last_cfg_q, s_q, s_d;
  logic [CntW-1:0]     addr_q, addr_d, pos_q, cnt_q;
  req_e                kind_q;
  logic [NeedW-1:0]    need_q;
  logic [GuidW-1:0]    thi_q, tlo_q, ghi_q, glo_q;
  logic [OrdW-1:0]     ord_q;

  logic [63:0]         cfg_ext, need_ext, st_ext, span_ext;
  logic [LBA_BITS-1:0] span;
  logic [CmpW-1:0]     s_plus_need;
  logic [CntW:0]       addr_inc;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [OutLbaW-1:0]  start_q, count_q;
  logic [GuidW-1:0]    othi_q, otlo_q, oghi_q, oglo_q;

  // Configuration registers, kept masked to the sector width.
  assign cfg_ext = 64'(cfg_data_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= LBA_BITS'(2048);
      last_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegFirstLba: first_q    <= cfg_ext[LBA_BITS-1:0];
        RegLastLba:  last_cfg_q <= cfg_ext[LBA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_e'(req_type_i);
      need_q <= {size_mb_i, SecShift'(0)};
      thi_q  <= type_hi_i;
      tlo_q  <= type_lo_i;
      ghi_q  <= part_guid_hi_i;
      glo_q  <= part_guid_lo_i;
      ord_q  <= entry_index_i;
    end
  end

  // Walk pointer.
  always_comb begin
    case (cmd_i.addr_op)
      ADDR_INC:  addr_d = addr_q + 1'b1;
      ADDR_DEC:  addr_d = addr_q - 1'b1;
      ADDR_ZERO: addr_d = '0;
      ADDR_ORD:  addr_d = CntW'(ord_q);
      ADDR_CNT:  addr_d = cnt_q;
      default:   addr_d = addr_q;
    endcase
  end

  // Search point: starts at the first usable sector, then steps past entries.
  always_comb begin
    s_d = s_q;
    if (cmd_i.load) begin
      s_d = first_q;
    end else if (cmd_i.s_adv) begin
      s_d = rd_q.last + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
      s_q    <= '0;
    end else begin
      addr_q <= addr_d;
      s_q    <= s_d;
      if (cmd_i.pos_save) begin
        pos_q <= addr_q;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // New extent placed at the search point.
  assign need_ext      = 64'(need_q);
  assign new_ent.thi   = thi_q;
  assign new_ent.tlo   = tlo_q;
  assign new_ent.ghi   = ghi_q;
  assign new_ent.glo   = glo_q;
  assign new_ent.start = s_q;
  assign new_ent.last  = s_q + need_ext[LBA_BITS-1:0] - 1'b1;

  // Table memory: one write port, one registered read port that follows the
  // next pointer value, so the read data matches the pointer after each edge.
  always_ff @(posedge clk_i) begin
    case (cmd_i.wr_op)
      WR_UP:   mem[addr_q[IdxW-1:0] + 1'b1] <= rd_q;
      WR_DOWN: mem[addr_q[IdxW-1:0] - 1'b1] <= rd_q;
      WR_NEW:  mem[addr_q[IdxW-1:0]]        <= new_ent;
      default: ;
    endcase
    rd_q <= mem[addr_d[IdxW-1:0]];
  end

  // Comparisons for the controller.
  assign s_plus_need = CmpW'(s_q) + CmpW'(need_q);
  assign addr_inc    = {1'b0, addr_q} + 1'b1;

  always_comb begin
    stat_o.kind            = kind_q;
    stat_o.type_null       = (thi_q | tlo_q) == '0;
    stat_o.guid_null       = (ghi_q | glo_q) == '0;
    stat_o.ord_ok          = 32'(ord_q) < 32'(cnt_q);
    stat_o.full            = cnt_q == CntW'(TABLE_ENTRIES);
    stat_o.addr_lt_cnt     = addr_q < cnt_q;
    stat_o.addr_inc_lt_cnt = addr_inc < {1'b0, cnt_q};
    stat_o.addr_eq_pos     = addr_q == pos_q;
    stat_o.start_lt_s      = rd_q.start < s_q;
    stat_o.start_le_s      = rd_q.start <= s_q;
    stat_o.s_le_last       = s_q <= last_cfg_q;
    stat_o.fit_in          = CmpW'(rd_q.start) >= s_plus_need;
    stat_o.fit_end         = CmpW'(last_cfg_q) + 1'b1 >= s_plus_need;
    stat_o.last_top        = rd_q.last == '1;
    stat_o.guid_match      = (rd_q.ghi == ghi_q) && (rd_q.glo == glo_q);
    stat_o.out_busy        = out_valid_q && !out_ready_i;
  end

  // Result register.
  assign span     = rd_q.last - rd_q.start + 1'b1;
  assign st_ext   = 64'(rd_q.start);
  assign span_ext = 64'(span);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_op != RES_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      RES_ERR: begin
        status_q <= cmd_i.res_code;
        start_q  <= '0;
        count_q  <= '0;
        othi_q   <= '0;
        otlo_q   <= '0;
        oghi_q   <= '0;
        oglo_q   <= '0;
      end
      RES_ENTRY: begin
        status_q <= StOk;
        start_q  <= st_ext[OutLbaW-1:0];
        count_q  <= span_ext[OutLbaW-1:0];
        othi_q   <= rd_q.thi;
        otlo_q   <= rd_q.tlo;
        oghi_q   <= rd_q.ghi;
        oglo_q   <= rd_q.glo;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign start_lba_o    = start_q;
  assign sector_count_o = count_q;
  assign out_type_hi_o  = othi_q;
  assign out_type_lo_o  = otlo_q;
  assign out_guid_hi_o  = oghi_q;
  assign out_guid_lo_o  = oglo_q;

endmodule

`default_nettype wire

// ===== rtl/pea_ctrl.sv =====
// ----------------------------------------------------------------------------
// pea_ctrl
// Controller: sequences the table walks of each request (first-fit search,
// insert position, shift up or down, guid search) and issues datapath
// commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pea_ctrl
  import pea_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pea_stat_t stat_i,
  output pea_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ERR,
    S_SRCH,
    S_POS,
    S_INS,
    S_INS_WR,
    S_NEW,
    S_NEW_WAIT,
    S_NEW_RES,
    S_FIND,
    S_LOOK_RES,
    S_DEL_RES,
    S_DEL_SHIFT,
    S_DEL_WR
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] err_q, err_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '{load: 1'b0, addr_op: ADDR_HOLD, s_adv: 1'b0, pos_save: 1'b0,
                wr_op: WR_NONE, cnt_inc: 1'b0, cnt_dec: 1'b0,
                res_op: RES_NONE, res_code: err_q};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.addr_op = ADDR_ZERO;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.kind)
          REQ_CREATE: begin
            if (stat_i.type_null || stat_i.guid_null) begin
              err_d   = StNoSpace;
              state_d = S_ERR;
            end else begin
              state_d = S_SRCH;
            end
          end
          REQ_LOOKUP_IDX: begin
            if (stat_i.ord_ok) begin
              cmd_o.addr_op = ADDR_ORD;
              state_d       = S_LOOK_RES;
            end else begin
              err_d   = StNotFound;
              state_d = S_ERR;
            end
          end
          default: begin
            if (stat_i.guid_null) begin
              err_d   = StNoSpace;
              state_d = S_ERR;
            end else begin
              state_d = S_FIND;
            end
          end
        endcase
      end
      S_ERR: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_op = RES_ERR;
          state_d      = S_IDLE;
        end
      end
      // First-fit search over the gaps, one entry per cycle.
      S_SRCH: begin
        if (!stat_i.s_le_last) begin
          err_d   = StNoSpace;
          state_d = S_ERR;
        end else if (stat_i.addr_lt_cnt && stat_i.start_lt_s) begin
          cmd_o.addr_op = ADDR_INC;
        end else if (!stat_i.addr_lt_cnt) begin
          if (stat_i.fit_end) begin
            state_d = stat_i.full ? S_ERR : S_POS;
            err_d   = StFull;
            cmd_o.addr_op = ADDR_ZERO;
          end else begin
            err_d   = StNoSpace;
            state_d = S_ERR;
          end
        end else if (stat_i.fit_in) begin
          state_d = stat_i.full ? S_ERR : S_POS;
          err_d   = StFull;
          cmd_o.addr_op = ADDR_ZERO;
        end else if (stat_i.last_top) begin
          err_d   = StNoSpace;
          state_d = S_ERR;
        end else begin
          cmd_o.s_adv   = 1'b1;
          cmd_o.addr_op = ADDR_INC;
        end
      end
      // Insert position: after every entry that starts at or below the point.
      S_POS: begin
        if (stat_i.addr_lt_cnt && stat_i.start_le_s) begin
          cmd_o.addr_op = ADDR_INC;
        end else begin
          cmd_o.pos_save = 1'b1;
          cmd_o.addr_op  = ADDR_CNT;
          state_d        = S_INS;
        end
      end
      // Open a slot by moving entries up, from the top down.
      S_INS: begin
        if (stat_i.addr_eq_pos) begin
          state_d = S_NEW;
        end else begin
          cmd_o.addr_op = ADDR_DEC;
          state_d       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_op = WR_UP;
        state_d     = S_INS;
      end
      S_NEW: begin
        cmd_o.wr_op   = WR_NEW;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_NEW_WAIT;
      end
      S_NEW_WAIT: begin
        state_d = S_NEW_RES;
      end
      S_NEW_RES, S_LOOK_RES: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_op = RES_ENTRY;
          state_d      = S_IDLE;
        end
      end
      // Guid search in table order.
      S_FIND: begin
        if (!stat_i.addr_lt_cnt) begin
          err_d   = StNotFound;
          state_d = S_ERR;
        end else if (stat_i.guid_match) begin
          state_d = (stat_i.kind == REQ_DELETE) ? S_DEL_RES : S_LOOK_RES;
        end else begin
          cmd_o.addr_op = ADDR_INC;
        end
      end
      S_DEL_RES: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_op = RES_ENTRY;
          state_d      = S_DEL_SHIFT;
        end
      end
      // Close the table up by moving later entries down.
      S_DEL_SHIFT: begin
        if (stat_i.addr_inc_lt_cnt) begin
          cmd_o.addr_op = ADDR_INC;
          state_d       = S_DEL_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_op = WR_DOWN;
        state_d     = S_DEL_SHIFT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= StOk;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/partition_extent_allocator.sv =====
// ----------------------------------------------------------------------------
// partition_extent_allocator
// Partition table of extents kept sorted by start sector, with first-fit
// create, delete by guid, lookup by guid and lookup by index.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_ready_o  req_type .. entry_index
//  out      output     out_valid_o/out_ready_i status .. out_guid_lo
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One request at a time. Guid requests search one entry per cycle; delete
//  then moves each later entry down in S_DEL_SHIFT and S_DEL_WR. Every walk,
//  including the search and shifts of create, goes through the single read
//  port of the table memory.
//  Reset empties the table at once through the used-entry count.
//  A result waiting on out_ready_i holds the block only when the next
//  result is due; configuration writes are always taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module partition_extent_allocator
  import pea_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries,
  parameter int LBA_BITS      = DefLbaBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [SizeW-1:0]    size_mb_i,
  input  logic [GuidW-1:0]    type_hi_i,
  input  logic [GuidW-1:0]    type_lo_i,
  input  logic [GuidW-1:0]    part_guid_hi_i,
  input  logic [GuidW-1:0]    part_guid_lo_i,
  input  logic [OrdW-1:0]     entry_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [OutLbaW-1:0]  start_lba_o,
  output logic [OutLbaW-1:0]  sector_count_o,
  output logic [GuidW-1:0]    out_type_hi_o,
  output logic [GuidW-1:0]    out_type_lo_o,
  output logic [GuidW-1:0]    out_guid_hi_o,
  output logic [GuidW-1:0]    out_guid_lo_o
);

  pea_cmd_t  cmd;
  pea_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  pea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, registers and result.
  pea_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LBA_BITS      (LBA_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .size_mb_i      (size_mb_i),
    .type_hi_i      (type_hi_i),
    .type_lo_i      (type_lo_i),
    .part_guid_hi_i (part_guid_hi_i),
    .part_guid_lo_i (part_guid_lo_i),
    .entry_index_i  (entry_index_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .start_lba_o    (start_lba_o),
    .sector_count_o (sector_count_o),
    .out_type_hi_o  (out_type_hi_o),
    .out_type_lo_o  (out_type_lo_o),
    .out_guid_hi_o  (out_guid_hi_o),
    .out_guid_lo_o  (out_guid_lo_o)
  );

  // A new result is never written over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.res_op != RES_NONE) |-> !stat.out_busy)
    else $error("result written while output stalled");

  // An entry is only added to a table that has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !stat.full)
    else $error("insert into full table");

  // A request in progress blocks the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

endmodule

`default_nettype wire
